// ----- hw/rtl/btn_dbnc_pkg.sv -----
// shared types and constants for the push-button debouncer with hold timer
package btn_dbnc_pkg;

	localparam logic [31:0] HOLD_SAT = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_PRESS   = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_QUIET   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_WAIT_PRESS     = 3'd0,
		PH_PRESS_STABLE   = 3'd1,
		PH_WAIT_RELEASE   = 3'd2,
		PH_RELEASE_STABLE = 3'd3,
		PH_QUIET_STABLE   = 3'd4
	} phase_t;

	localparam logic CFG_DEBOUNCE_LIMIT = 1'b0;
	localparam logic CFG_ACTIVE_LOW     = 1'b1;

	localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd20;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[32] ? HOLD_SAT : s[31:0];
	endfunction

endpackage

// ----- hw/rtl/button_debounce_hold_timer.sv -----
// push-button debouncer with hold-time measurement, top level
// an accepted item goes through the input register, then the result register
// throughput: one item per cycle; the state update is a single pass of saturating adds
// and compares between the input register and the result register
// backpressure on the result side stalls both stages together
// reset: arst_n clears phase, timers, events and valids; limit 20 ms, active high pin
module button_debounce_hold_timer
	import btn_dbnc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        pin_level,
	input  logic [15:0] elapsed_ms,
	input  logic        take_down,
	input  logic        take_up,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        down_seen,
	output logic        up_seen,
	output logic [31:0] released_hold_ms,
	output logic        held_now,
	output logic [31:0] current_hold_ms
);

	logic [7:0]  limit_q;
	logic        active_low_q;

	logic        valid_s1;
	mode_t       mode_s1;
	logic        pin_s1;
	logic [15:0] dt_s1;
	logic        take_down_s1;
	logic        take_up_s1;

	phase_t      phase_q, phase_d;
	logic [31:0] stable_q, stable_d;
	logic [31:0] hold_q, hold_d;
	logic        dpend_q, dpend_d, dpend_n;
	logic        upend_q, upend_d, upend_n;

	logic        out_valid_q;
	logic        down_seen_q, up_seen_q, held_now_q;
	logic [31:0] released_q, current_q;

	logic        advance;
	logic        work;
	logic        pressed;
	logic [31:0] stable_add, hold_add;
	logic        dseen, useen, held;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign work      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= DEBOUNCE_LIMIT_RST;
			active_low_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_LIMIT: limit_q      <= cfg_data;
				CFG_ACTIVE_LOW:     active_low_q <= cfg_data[0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1      <= mode_t'(mode);
			pin_s1       <= pin_level;
			dt_s1        <= elapsed_ms;
			take_down_s1 <= take_down;
			take_up_s1   <= take_up;
		end
	end

	assign pressed    = active_low_q ? !pin_s1 : pin_s1;
	assign stable_add = sat_add(stable_q, dt_s1);
	assign hold_add   = sat_add(hold_q, dt_s1);

	always_comb begin
		phase_d  = phase_q;
		stable_d = stable_q;
		hold_d   = hold_q;
		dpend_d  = dpend_q;
		upend_d  = upend_q;
		unique case (mode_s1)
			MODE_TICK: begin
				unique case (phase_q)
					PH_PRESS_STABLE: begin
						if (pressed) begin
							stable_d = stable_add;
							if (stable_add > {24'b0, limit_q}) begin
								phase_d = PH_WAIT_RELEASE;
								hold_d  = stable_add;
								dpend_d = 1'b1;
							end
						end else begin
							phase_d = PH_WAIT_PRESS;
						end
					end
					PH_WAIT_RELEASE: begin
						if (pressed) begin
							hold_d = hold_add;
						end else begin
							phase_d  = PH_RELEASE_STABLE;
							stable_d = 32'd0;
						end
					end
					PH_RELEASE_STABLE, PH_QUIET_STABLE: begin
						if (!pressed) begin
							stable_d = stable_add;
							if (stable_add > {24'b0, limit_q}) begin
								if (phase_q == PH_RELEASE_STABLE)
									upend_d = 1'b1;
								phase_d = PH_WAIT_PRESS;
							end
						end else begin
							stable_d = 32'd0;
						end
					end
					default: begin
						if (pressed) begin
							phase_d  = PH_PRESS_STABLE;
							stable_d = 32'd0;
						end
					end
				endcase
			end
			MODE_PRESS: begin
				phase_d = PH_WAIT_RELEASE;
				hold_d  = 32'd0;
				dpend_d = 1'b1;
			end
			MODE_RELEASE: begin
				phase_d = PH_WAIT_PRESS;
				upend_d = 1'b1;
			end
			MODE_QUIET: begin
				phase_d = PH_QUIET_STABLE;
				upend_d = 1'b0;
				dpend_d = 1'b0;
				hold_d  = 32'd0;
			end
		endcase
		dseen   = take_down_s1 && dpend_d;
		useen   = take_up_s1 && upend_d;
		dpend_n = dpend_d && !dseen;
		upend_n = upend_d && !useen;
		held    = (phase_d == PH_WAIT_RELEASE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_PRESS;
			stable_q <= 32'd0;
			hold_q   <= 32'd0;
			dpend_q  <= 1'b0;
			upend_q  <= 1'b0;
		end else if (work) begin
			phase_q  <= phase_d;
			stable_q <= stable_d;
			hold_q   <= hold_d;
			dpend_q  <= dpend_n;
			upend_q  <= upend_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			down_seen_q <= dseen;
			up_seen_q   <= useen;
			released_q  <= useen ? hold_d : 32'd0;
			held_now_q  <= held;
			current_q   <= held ? hold_d : 32'd0;
		end
	end

	assign out_valid        = out_valid_q;
	assign down_seen        = down_seen_q;
	assign up_seen          = up_seen_q;
	assign released_hold_ms = released_q;
	assign held_now         = held_now_q;
	assign current_hold_ms  = current_q;

endmodule

// ----- hw/rtl/button_debounce_hold_timer_chk.sv -----
// port-level assertions for the debouncer, bound to the top level
module button_debounce_hold_timer_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        down_seen,
	input logic        up_seen,
	input logic [31:0] released_hold_ms,
	input logic        held_now,
	input logic [31:0] current_hold_ms
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(down_seen) && $stable(up_seen)
			&& $stable(released_hold_ms) && $stable(held_now) && $stable(current_hold_ms))
		else $error("stalled result item changed");

	a_cur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !held_now |-> current_hold_ms == 32'd0)
		else $error("current hold nonzero while not held");

	a_rel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !up_seen |-> released_hold_ms == 32'd0)
		else $error("released hold nonzero without release event");

	// a rising result valid must be matched by an earlier accepted input item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without matching input item");

endmodule

bind button_debounce_hold_timer button_debounce_hold_timer_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.down_seen        (down_seen),
	.up_seen          (up_seen),
	.released_hold_ms (released_hold_ms),
	.held_now         (held_now),
	.current_hold_ms  (current_hold_ms)
);
